>>> rtl/rpab_pkg.sv
// Shared types and constants for the RGBA pixel alpha blend block.
// Used by rgba_pixel_alpha_blend; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rpab_pkg;

  localparam logic [7:0] OPAQUE     = 8'd255;
  localparam logic [7:0] ROUND_HALF = 8'h80;

  // One quotient bit is resolved per division stage.
  localparam int unsigned NUM_DIV = 8;

  typedef enum logic [1:0] {
    MODE_KEEP,
    MODE_COPY,
    MODE_BLEND
  } mode_e;

  typedef struct packed {
    logic [7:0] sr;
    logic [7:0] sg;
    logic [7:0] sb;
    logic [7:0] sa;
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    logic [7:0] da;
    mode_e      mode;
  } pix_t;

endpackage

`default_nettype wire

>>> rtl/rgba_pixel_alpha_blend.sv
// Top level of the RGBA "over" alpha blend pipeline, one pixel per item.
// Depends on rpab_pkg for the pixel struct, mode codes and constants.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one source and one destination RGBA pixel per item and
// returns the blended destination pixel, at one item per clock when the
// output side keeps up. Stage 0 forms dstA*(255-srcA), stage 1 divides it
// by 255 with a reciprocal multiply and sets up the weight division, the
// division stages resolve the 8-bit colour weight one quotient bit per
// stage, the multiply stage multiplies the four channel deltas, and the
// output stage rounds and registers the result. Each stage holds its own
// valid bit, so a stall at the output only holds the stages that are full
// and empty stages keep taking new items.
module rgba_pixel_alpha_blend (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [7:0] src_red_i,
  input  wire  [7:0] src_green_i,
  input  wire  [7:0] src_blue_i,
  input  wire  [7:0] src_alpha_i,
  input  wire  [7:0] dst_red_i,
  input  wire  [7:0] dst_green_i,
  input  wire  [7:0] dst_blue_i,
  input  wire  [7:0] dst_alpha_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o
);

  localparam int unsigned ND = rpab_pkg::NUM_DIV;

  // Stage enables.
  logic          en0;
  logic          en1;
  logic [ND-1:0] en_div;
  logic          en_mul;
  logic          en_out;

  // Stage 0: classification and dstA*(255-srcA).
  logic            v0_q;
  rpab_pkg::pix_t  pix0_q, pix0_d;
  logic [15:0]     prod0_q, prod0_d;

  // Stage 1: divisor and dividend of the weight division.
  logic            v1_q;
  rpab_pkg::pix_t  pix1_q;
  logic [25:0]     recip;
  logic [15:0]     num1;
  logic [7:0]      den1_q, den1_d;
  logic [7:0]      rem1_q, rem1_d;
  logic [7:0]      lo1_q, lo1_d;

  // Division stages.
  logic [ND-1:0]   vd_q;
  rpab_pkg::pix_t  pixd_q [ND];
  logic [7:0]      dend_q [ND];
  logic [7:0]      remd_q [ND];
  logic [7:0]      remd_d [ND];
  logic [7:0]      lod_q  [ND];
  logic [7:0]      lod_d  [ND];
  logic [7:0]      rin    [ND];
  logic [7:0]      lin    [ND];
  logic [7:0]      din    [ND];
  logic [8:0]      r9     [ND];
  logic [8:0]      sub9   [ND];

  // Multiply stage: channel 0..2 are red, green, blue and 3 is alpha.
  logic            vm_q;
  rpab_pkg::pix_t  pixm_q;
  logic [17:0]     tm_q [4];
  logic [17:0]     tm_d [4];
  logic [7:0]      tgt  [4];
  logic [7:0]      old  [4];
  logic [8:0]      dlt  [4];
  logic [7:0]      kwt  [4];
  logic [7:0]      oldm [4];

  // Output stage.
  logic            vo_q;
  logic [7:0]      out_q [4];
  logic [7:0]      out_d [4];
  logic [18:0]     rnd   [4];
  logic [7:0]      blend [4];

  // Handshake chain: a stage may load when it is empty or its item moves on.
  always_comb begin
    en_out = ~vo_q | out_ready_i;
    en_mul = ~vm_q | en_out;
    en_div[ND-1] = ~vd_q[ND-1] | en_mul;
    for (int j = ND - 2; j >= 0; j--) begin
      en_div[j] = ~vd_q[j] | en_div[j+1];
    end
    en1 = ~v1_q | en_div[0];
    en0 = ~v0_q | en1;
  end

  assign in_ready_o = en0;

  // Stage 0.
  always_comb begin
    pix0_d.sr = src_red_i;
    pix0_d.sg = src_green_i;
    pix0_d.sb = src_blue_i;
    pix0_d.sa = src_alpha_i;
    pix0_d.dr = dst_red_i;
    pix0_d.dg = dst_green_i;
    pix0_d.db = dst_blue_i;
    pix0_d.da = dst_alpha_i;
    if (src_alpha_i == 8'd0) begin
      pix0_d.mode = rpab_pkg::MODE_KEEP;
    end else if (src_alpha_i == rpab_pkg::OPAQUE) begin
      pix0_d.mode = rpab_pkg::MODE_COPY;
    end else begin
      pix0_d.mode = rpab_pkg::MODE_BLEND;
    end
    prod0_d = 16'(dst_alpha_i) * 16'(rpab_pkg::OPAQUE - src_alpha_i);
  end

  // Stage 1: floor(p/255) is ((p+1)*257) >> 16 for every product that occurs.
  always_comb begin
    recip  = (26'(prod0_q) + 26'd1) * 26'd257;
    den1_d = pix0_q.sa + recip[23:16];
    num1   = {pix0_q.sa, 8'h00} - 16'(pix0_q.sa);
    rem1_d = num1[15:8];
    lo1_d  = num1[7:0];
  end

  // Restoring division, one quotient bit per stage. The quotient bits shift
  // into the low dividend byte as its bits shift out.
  always_comb begin
    rin[0] = rem1_q;
    lin[0] = lo1_q;
    din[0] = den1_q;
    for (int j = 1; j < ND; j++) begin
      rin[j] = remd_q[j-1];
      lin[j] = lod_q[j-1];
      din[j] = dend_q[j-1];
    end
    for (int j = 0; j < ND; j++) begin
      r9[j]   = {rin[j], lin[j][7]};
      sub9[j] = r9[j] - {1'b0, din[j]};
      if (r9[j] >= {1'b0, din[j]}) begin
        remd_d[j] = sub9[j][7:0];
        lod_d[j]  = {lin[j][6:0], 1'b1};
      end else begin
        remd_d[j] = r9[j][7:0];
        lod_d[j]  = {lin[j][6:0], 1'b0};
      end
    end
  end

  // Multiply stage: (target - old) * k in 18-bit two's complement.
  always_comb begin
    tgt[0] = pixd_q[ND-1].sr;
    tgt[1] = pixd_q[ND-1].sg;
    tgt[2] = pixd_q[ND-1].sb;
    tgt[3] = rpab_pkg::OPAQUE;
    old[0] = pixd_q[ND-1].dr;
    old[1] = pixd_q[ND-1].dg;
    old[2] = pixd_q[ND-1].db;
    old[3] = pixd_q[ND-1].da;
    kwt[0] = lod_q[ND-1];
    kwt[1] = lod_q[ND-1];
    kwt[2] = lod_q[ND-1];
    kwt[3] = pixd_q[ND-1].sa;
    for (int c = 0; c < 4; c++) begin
      dlt[c]  = {1'b0, tgt[c]} - {1'b0, old[c]};
      tm_d[c] = {{9{dlt[c][8]}}, dlt[c]} * {10'b0, kwt[c]};
    end
  end

  // Output stage: floor((t + floor(t/256) + 0x80) / 256) added to the old value.
  always_comb begin
    oldm[0] = pixm_q.dr;
    oldm[1] = pixm_q.dg;
    oldm[2] = pixm_q.db;
    oldm[3] = pixm_q.da;
    for (int c = 0; c < 4; c++) begin
      rnd[c]   = {tm_q[c][17], tm_q[c]} + {{9{tm_q[c][17]}}, tm_q[c][17:8]}
                 + {11'b0, rpab_pkg::ROUND_HALF};
      blend[c] = oldm[c] + rnd[c][15:8];
    end
    case (pixm_q.mode)
      rpab_pkg::MODE_KEEP: begin
        out_d[0] = pixm_q.dr;
        out_d[1] = pixm_q.dg;
        out_d[2] = pixm_q.db;
        out_d[3] = pixm_q.da;
      end
      rpab_pkg::MODE_COPY: begin
        out_d[0] = pixm_q.sr;
        out_d[1] = pixm_q.sg;
        out_d[2] = pixm_q.sb;
        out_d[3] = pixm_q.sa;
      end
      default: begin
        out_d = blend;
      end
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      vd_q <= '0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en0) begin
        v0_q <= in_valid_i;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
      if (en_div[0]) begin
        vd_q[0] <= v1_q;
      end
      for (int j = 1; j < ND; j++) begin
        if (en_div[j]) begin
          vd_q[j] <= vd_q[j-1];
        end
      end
      if (en_mul) begin
        vm_q <= vd_q[ND-1];
      end
      if (en_out) begin
        vo_q <= vm_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en0) begin
      pix0_q  <= pix0_d;
      prod0_q <= prod0_d;
    end
    if (en1) begin
      pix1_q <= pix0_q;
      den1_q <= den1_d;
      rem1_q <= rem1_d;
      lo1_q  <= lo1_d;
    end
    if (en_div[0]) begin
      pixd_q[0] <= pix1_q;
    end
    for (int j = 1; j < ND; j++) begin
      if (en_div[j]) begin
        pixd_q[j] <= pixd_q[j-1];
      end
    end
    for (int j = 0; j < ND; j++) begin
      if (en_div[j]) begin
        dend_q[j] <= din[j];
        remd_q[j] <= remd_d[j];
        lod_q[j]  <= lod_d[j];
      end
    end
    if (en_mul) begin
      pixm_q <= pixd_q[ND-1];
      tm_q   <= tm_d;
    end
    if (en_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_q[3];

  // An empty output register lets every stage load, so the input is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  // A ready output side never holds back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while the output side is ready");

  // The division remainder of a blended item stays below its divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd_q[ND-1] && pixd_q[ND-1].mode == rpab_pkg::MODE_BLEND)
      |-> (remd_q[ND-1] < dend_q[ND-1]))
    else $error("weight division remainder not below divisor");

endmodule

`default_nettype wire
